// ----- rtl/imufp_pkg.sv -----
// Package for the IMU serial frame parser: frame codes, widths and axis scaling.
// No dependencies; used by the channel interfaces and the top level.
package imufp_pkg;

  localparam int FRAME_BYTES   = 11;
  localparam int IDX_W         = 4;
  localparam int PAYLOAD_BYTES = 6;
  localparam int PAY_IDX_W     = 3;
  localparam int AXIS_W        = 16;
  localparam int MUL_W         = 9;
  localparam int PROD_W        = AXIS_W + MUL_W;

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;
  localparam logic [7:0] TYPE_RATE   = 8'h52;

  localparam logic [IDX_W-1:0] IDX_TYPE = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_PAY0 = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 1);

  localparam logic KIND_ANGLE = 1'b0;
  localparam logic KIND_RATE  = 1'b1;

  // angle: deg Q7 = raw*180/32768*128 ; rate: deg/s Q4 = raw*2000/32768*16
  localparam logic signed [MUL_W-1:0] ANGLE_MUL = 9'sd180;
  localparam logic signed [MUL_W-1:0] RATE_MUL  = 9'sd125;
  localparam int ANGLE_SH = 8;
  localparam int RATE_SH  = 7;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [7:0] byte_t;

  // floor(raw * mul / 2^sh), arithmetic shift
  function automatic axis_t scale_axis(input axis_t raw, input logic kind);
    logic signed [MUL_W-1:0]  mul;
    logic signed [PROD_W-1:0] prod;
    mul  = (kind == KIND_RATE) ? RATE_MUL : ANGLE_MUL;
    prod = PROD_W'(raw) * PROD_W'(mul);
    if (kind == KIND_RATE) begin
      return axis_t'(prod >>> RATE_SH);
    end
    return axis_t'(prod >>> ANGLE_SH);
  endfunction

endpackage

// ----- rtl/imufp_if.sv -----
// Valid/ready channel interfaces of the IMU frame parser: byte input and result output.
// Depends on imufp_pkg for payload types.
interface imufp_in_if import imufp_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufp_out_if import imufp_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  frame_kind;
  axis_t axis_x;
  axis_t axis_y;
  axis_t axis_z;

  modport source (output valid, output frame_kind, output axis_x, output axis_y,
                  output axis_z, input ready);
  modport sink   (input valid, input frame_kind, input axis_x, input axis_y,
                  input axis_z, output ready);
endinterface

// ----- rtl/imu_uart_frame_parser_top.sv -----
// IMU serial frame parser top level: frame hunt, checksum, axis scaling.
// Depends on imufp_pkg and the channel interfaces in imufp_if.sv.
//
// Usage:
//   in_bus carries one received serial byte per item (valid/ready). The parser
//   hunts for header 0x55, gathers an 11-byte frame and checks the 8-bit sum.
//   A good angle frame (type 0x53) or rate frame (type 0x52) gives one item on
//   out_bus: frame_kind plus signed X/Y/Z (angle deg Q7, rate deg/s Q4).
//   Bad frames and other types give nothing; hunting resumes after each frame.
// Timing:
//   One byte accepted per cycle while in_bus.ready is high. The edge that accepts
//   a frame's checksum byte loads the frame stage register; the output register
//   is loaded from it through the three 16x9 multipliers once it can advance.
// Reset and stall:
//   Synchronous reset returns to hunting with both result stages empty.
//   When out_bus stalls, the output register holds; a second finished frame
//   waits in the frame stage, and in_bus.ready drops only while both are full.
module imu_uart_frame_parser_top
  import imufp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  imufp_in_if.sink           in_bus,
  imufp_out_if.source        out_bus
);

  logic                 active_r, active_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  byte_t                sum_r, sum_nxt;
  byte_t                type_r, type_nxt;
  byte_t                pay_r [PAYLOAD_BYTES];
  logic [PAY_IDX_W-1:0] pay_idx;
  logic                 pay_we;

  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_kind_r;
  axis_t                s1_x_r, s1_y_r, s1_z_r;
  logic                 s1_load, s1_adv;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r;
  axis_t                out_x_r, out_y_r, out_z_r;

  logic                 in_acc;
  logic                 type_ok;

  assign s1_adv        = !out_valid_r || out_bus.ready;
  assign in_bus.ready  = !s1_valid_r || s1_adv;
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign pay_idx       = PAY_IDX_W'(idx_r - IDX_PAY0);
  assign type_ok       = (type_r == TYPE_ANGLE) || (type_r == TYPE_RATE);

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    type_nxt   = type_r;
    pay_we     = 1'b0;
    s1_load    = 1'b0;
    if (in_acc) begin
      if (!active_r) begin
        if (in_bus.rx_byte == HEADER_BYTE) begin
          active_nxt = 1'b1;
          idx_nxt    = IDX_TYPE;
          sum_nxt    = in_bus.rx_byte;
        end
      end else if (idx_r != IDX_LAST) begin
        if (idx_r == IDX_TYPE) begin
          type_nxt = in_bus.rx_byte;
        end else begin
          pay_we = (32'(pay_idx) < PAYLOAD_BYTES);
        end
        sum_nxt = sum_r + in_bus.rx_byte;
        idx_nxt = idx_r + IDX_W'(1);
      end else begin
        active_nxt = 1'b0;
        idx_nxt    = '0;
        sum_nxt    = '0;
        s1_load    = (in_bus.rx_byte == sum_r) && type_ok;
      end
    end
  end

  always_comb begin
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_valid_r && s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      sum_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      sum_r       <= sum_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    type_r <= type_nxt;
    if (pay_we) begin
      pay_r[pay_idx] <= in_bus.rx_byte;
    end
    if (s1_load) begin
      s1_kind_r <= (type_r == TYPE_RATE) ? KIND_RATE : KIND_ANGLE;
      s1_x_r    <= axis_t'({pay_r[1], pay_r[0]});
      s1_y_r    <= axis_t'({pay_r[3], pay_r[2]});
      s1_z_r    <= axis_t'({pay_r[5], pay_r[4]});
    end
    if (s1_valid_r && s1_adv) begin
      out_kind_r <= s1_kind_r;
      out_x_r    <= scale_axis(s1_x_r, s1_kind_r);
      out_y_r    <= scale_axis(s1_y_r, s1_kind_r);
      out_z_r    <= scale_axis(s1_z_r, s1_kind_r);
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.frame_kind = out_kind_r;
  assign out_bus.axis_x     = out_x_r;
  assign out_bus.axis_y     = out_y_r;
  assign out_bus.axis_z     = out_z_r;

`ifndef SYNTH
  // inside a frame the index always points at a byte after the header
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r != '0) && (idx_r <= IDX_LAST))
    else $error("frame index out of range while active");

  // a finished frame only comes from a checksum byte taken at the last index
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |-> in_acc && active_r && (idx_r == IDX_LAST))
    else $error("frame stage loaded outside the checksum byte");

  // a stalled frame stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_x_r) && $stable(s1_kind_r))
    else $error("frame stage item lost under stall");
`endif

endmodule
